[rtl/c8ic_pkg.sv]
// shared constants, types and the font table for the chip-8 instruction cycle block
package c8ic_pkg;

    localparam int MEMORY_BYTES = 4096;
    localparam int SCREEN_ROWS  = 32;
    localparam int SCREEN_COLS  = 64;
    localparam int STACK_DEPTH  = 16;

    localparam logic [11:0] PC_START  = 12'h200;
    localparam int          FONT_SIZE = 80;

    // operation codes of an input beat
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_EXEC  = 2'd1;
    localparam logic [1:0] OP_ROW   = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    typedef logic [7:0]  byte_t;
    typedef logic [11:0] addr_t;

    function automatic byte_t font_byte(input logic [6:0] a);
        byte_t t [0:79];
        t = '{8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
              8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
              8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
              8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
              8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
              8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
              8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
              8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80};
        if (a < 7'd80)
            return t[a];
        return 8'h00;
    endfunction

endpackage

[rtl/c8ic_ram.sv]
// generic single port ram with registered read
module c8ic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

[rtl/chip8_instruction_cycle.sv]
// chip-8 processor: memory, registers, stack, timers and screen behind one beat channel
// a beat takes a time set by its kind (write, row or memory read, instruction, return, bcd,
// store, load, sprite, screen clear) and, for store, load and sprite, by the registers or rows
// one beat at a time; the single port main memory sets the time, result stalls add to it
// after reset a clearing pass loads the font and zeroes main memory, then the screen is
// cleared; no beat is accepted meanwhile
module chip8_instruction_cycle #(
    parameter int MEMORY_BYTES = c8ic_pkg::MEMORY_BYTES,
    parameter int SCREEN_ROWS  = c8ic_pkg::SCREEN_ROWS,
    parameter int SCREEN_COLS  = c8ic_pkg::SCREEN_COLS,
    parameter int STACK_DEPTH  = c8ic_pkg::STACK_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [11:0] address,
    input  logic [7:0]  data_byte,
    input  logic [15:0] keys,
    input  logic [7:0]  random_byte,
    input  logic [4:0]  row_select,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_byte,
    output logic [SCREEN_COLS-1:0] screen_row,
    output logic [11:0] program_counter,
    output logic        draw_pending,
    output logic        sound_on,
    output logic        waiting_key
);

    localparam int MAW = $clog2(MEMORY_BYTES);
    localparam int RAW = $clog2(SCREEN_ROWS);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);

    // sequencer states
    localparam logic [4:0] S_CLRMEM = 5'd0;
    localparam logic [4:0] S_CLRSCR = 5'd1;
    localparam logic [4:0] S_IDLE   = 5'd2;
    localparam logic [4:0] S_RDWAIT = 5'd3;
    localparam logic [4:0] S_FETCH1 = 5'd4;
    localparam logic [4:0] S_FETCH2 = 5'd5;
    localparam logic [4:0] S_DECODE = 5'd6;
    localparam logic [4:0] S_STKRD  = 5'd7;
    localparam logic [4:0] S_RET    = 5'd8;
    localparam logic [4:0] S_CLS    = 5'd9;
    localparam logic [4:0] S_DRADDR = 5'd10;
    localparam logic [4:0] S_DRWAIT = 5'd11;
    localparam logic [4:0] S_DRROW  = 5'd12;
    localparam logic [4:0] S_DRWR   = 5'd13;
    localparam logic [4:0] S_BCD    = 5'd14;
    localparam logic [4:0] S_STORE  = 5'd15;
    localparam logic [4:0] S_LDADDR = 5'd16;
    localparam logic [4:0] S_LDWAIT = 5'd17;
    localparam logic [4:0] S_LDDATA = 5'd18;
    localparam logic [4:0] S_FINISH = 5'd19;
    localparam logic [4:0] S_OUT    = 5'd20;

    logic [4:0] state_reg, state_next;

    // main memory port
    logic           mem_we;
    logic [MAW-1:0] mem_addr;
    logic [7:0]     mem_wdata, mem_rdata;

    c8ic_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
        .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
    );

    // screen memory port
    logic                   scr_we;
    logic [RAW-1:0]         scr_addr;
    logic [SCREEN_COLS-1:0] scr_wdata, scr_rdata;

    c8ic_ram #(.WIDTH(SCREEN_COLS), .DEPTH(SCREEN_ROWS)) u_scr (
        .clk(clk), .we(scr_we), .addr(scr_addr), .wdata(scr_wdata), .rdata(scr_rdata)
    );

    // return stack memory
    logic           stk_we;
    logic [SAW-1:0] stk_addr;
    logic [11:0]    stk_wdata, stk_rdata;

    c8ic_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stk (
        .clk(clk), .we(stk_we), .addr(stk_addr), .wdata(stk_wdata), .rdata(stk_rdata)
    );

    // architectural registers
    logic [7:0]     v_reg [0:15];
    logic [7:0]     v_next [0:15];
    logic [11:0]    pc_reg, pc_next;
    logic [11:0]    idx_reg, idx_next;
    logic [7:0]     dly_reg, dly_next;
    logic [7:0]     snd_reg, snd_next;
    logic [SCW-1:0] sp_reg, sp_next;
    logic           mark_reg, mark_next;

    // beat capture and working registers
    logic [1:0]     op_reg;
    logic [15:0]    keys_reg;
    logic [7:0]     rnd_reg;
    logic [RAW-1:0] rsel_reg;
    logic [15:0]    ins_reg, ins_next;
    logic [MAW-1:0] cnt_reg, cnt_next;
    logic [7:0]     spr_reg, spr_next;
    logic           hit_reg, hit_next;
    logic           wait_reg, wait_next;

    logic [7:0]             ob_reg, ob_next;
    logic [SCREEN_COLS-1:0] orow_reg, orow_next;
    logic                   ovalid_reg, ovalid_next;
    logic                   owait_reg, owait_next;

    // instruction fields
    logic [3:0]  fx, fy, fn;
    logic [7:0]  kk, vx, vy;
    logic [11:0] nnn;
    assign fx  = ins_reg[11:8];
    assign fy  = ins_reg[7:4];
    assign fn  = ins_reg[3:0];
    assign kk  = ins_reg[7:0];
    assign nnn = ins_reg[11:0];
    assign vx  = v_reg[fx];
    assign vy  = v_reg[fy];

    logic accept;
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // sprite row placement, bcd digits, lowest pressed key and sums
    logic [8:0]             ypos;
    logic [8:0]             xpos;
    logic [SCREEN_COLS+7:0] spr_wide;
    logic [SCREEN_COLS-1:0] spr_mask;
    logic [4:0]             bcd_h, bcd_t, bcd_o;
    logic [7:0]             bcd_r;
    logic [3:0]             key_lo;
    logic                   key_hit;
    logic [12:0]            isum;
    logic [8:0]             asum;

    always_comb
    begin
        ypos     = {1'b0, vy} + 9'(cnt_reg[3:0]);
        xpos     = {1'b0, vx};
        spr_wide = {spr_reg, {SCREEN_COLS{1'b0}}} >> xpos;
        spr_mask = spr_wide[SCREEN_COLS+7:8];
        // digits: hundreds by compare, tens by multiply and shift, ones by subtract
        bcd_h = (vx >= 8'd200) ? 5'd2 : ((vx >= 8'd100) ? 5'd1 : 5'd0);
        bcd_r = vx - 8'({3'd0, bcd_h} * 8'd100);
        bcd_t = 5'(({8'd0, bcd_r} * 16'd205) >> 11);
        bcd_o = 5'(bcd_r - 8'({3'd0, bcd_t} * 8'd10));
        key_lo  = 4'd0;
        key_hit = 1'b0;
        for (int k = 15; k >= 0; k--)
        begin
            if (keys_reg[k])
            begin
                key_lo  = 4'(k);
                key_hit = 1'b1;
            end
        end
        isum = {1'b0, idx_reg} + {5'd0, vx};
        asum = {1'b0, vx} + {1'b0, vy};
    end

    // next state logic
    always_comb
    begin
        state_next = state_reg;
        pc_next = pc_reg; idx_next = idx_reg; dly_next = dly_reg; snd_next = snd_reg;
        sp_next = sp_reg; mark_next = mark_reg;
        for (int i = 0; i < 16; i++)
            v_next[i] = v_reg[i];
        ins_next = ins_reg; cnt_next = cnt_reg; spr_next = spr_reg; wait_next = wait_reg;
        hit_next = hit_reg;
        ob_next = ob_reg; orow_next = orow_reg; ovalid_next = ovalid_reg;
        owait_next = owait_reg;
        mem_we = 1'b0; mem_addr = pc_reg; mem_wdata = 8'd0;
        scr_we = 1'b0; scr_addr = rsel_reg; scr_wdata = '0;
        stk_we = 1'b0; stk_addr = SAW'(sp_reg - SCW'(1)); stk_wdata = pc_reg;

        unique case (state_reg)
            S_CLRMEM:
            begin
                mem_we    = 1'b1;
                mem_addr  = cnt_reg;
                mem_wdata = font_val(cnt_reg);
                cnt_next  = cnt_reg + MAW'(1);
                if (cnt_reg == MAW'(MEMORY_BYTES - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_CLRSCR;
                end
            end
            S_CLRSCR, S_CLS:
            begin
                scr_we   = 1'b1;
                scr_addr = cnt_reg[RAW-1:0];
                cnt_next = cnt_reg + MAW'(1);
                if (cnt_reg[RAW-1:0] == RAW'(SCREEN_ROWS - 1))
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == S_CLS) ? S_FINISH : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    wait_next = 1'b0;
                    cnt_next  = '0;
                    unique case (opcode)
                        c8ic_pkg::OP_WRITE:
                        begin
                            mem_we = 1'b1; mem_addr = address; mem_wdata = data_byte;
                            ob_next = 8'd0; orow_next = '0; state_next = S_OUT;
                        end
                        c8ic_pkg::OP_EXEC:
                        begin
                            mem_addr = pc_reg; state_next = S_FETCH1;
                        end
                        c8ic_pkg::OP_ROW:
                        begin
                            scr_addr = row_select[RAW-1:0]; state_next = S_RDWAIT;
                        end
                        c8ic_pkg::OP_READ:
                        begin
                            mem_addr = address; state_next = S_RDWAIT;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_RDWAIT:
            begin
                ob_next    = (op_reg == c8ic_pkg::OP_READ) ? mem_rdata : 8'd0;
                orow_next  = (op_reg == c8ic_pkg::OP_ROW) ? scr_rdata : '0;
                state_next = S_OUT;
            end
            S_FETCH1:
            begin
                ins_next[15:8] = mem_rdata;
                mem_addr   = pc_reg + 12'd1;
                state_next = S_FETCH2;
            end
            S_FETCH2:
            begin
                ins_next[7:0] = mem_rdata;
                state_next = S_DECODE;
            end
            S_DECODE:
            begin
                pc_next    = pc_reg + 12'd2;
                state_next = S_FINISH;
                unique case (ins_reg[15:12])
                    4'h0:
                    begin
                        if (ins_reg == 16'h00E0)
                        begin
                            state_next = S_CLS;
                        end
                        else if (ins_reg == 16'h00EE && sp_reg != '0)
                        begin
                            stk_addr   = SAW'(sp_reg - SCW'(1));
                            sp_next    = sp_reg - SCW'(1);
                            state_next = S_STKRD;
                        end
                    end
                    4'h1: pc_next = nnn;
                    4'h2:
                    begin
                        if (sp_reg < SCW'(STACK_DEPTH))
                        begin
                            stk_we = 1'b1; stk_addr = sp_reg[SAW-1:0];
                            stk_wdata = pc_reg + 12'd2;
                            sp_next = sp_reg + SCW'(1);
                            pc_next = nnn;
                        end
                    end
                    4'h3: if (vx == kk) pc_next = pc_reg + 12'd4;
                    4'h4: if (vx != kk) pc_next = pc_reg + 12'd4;
                    4'h5: if (vx == vy) pc_next = pc_reg + 12'd4;
                    4'h6: v_next[fx] = kk;
                    4'h7: v_next[fx] = vx + kk;
                    4'h8:
                    begin
                        unique case (fn)
                            4'h0: v_next[fx] = vy;
                            4'h1: v_next[fx] = vx | vy;
                            4'h2: v_next[fx] = vx & vy;
                            4'h3: v_next[fx] = vx ^ vy;
                            4'h4:
                            begin
                                v_next[fx] = asum[7:0]; v_next[15] = {7'd0, asum[8]};
                            end
                            4'h5:
                            begin
                                v_next[fx] = vx - vy; v_next[15] = {7'd0, vx >= vy};
                            end
                            4'h6:
                            begin
                                v_next[fx] = vx >> 1; v_next[15] = {7'd0, vx[0]};
                            end
                            4'h7:
                            begin
                                v_next[fx] = vy - vx; v_next[15] = {7'd0, vy >= vx};
                            end
                            4'hE:
                            begin
                                v_next[fx] = vx << 1; v_next[15] = {7'd0, vx[7]};
                            end
                            default: v_next[fx] = vx;
                        endcase
                    end
                    4'h9: if (vx != vy) pc_next = pc_reg + 12'd4;
                    4'hA: idx_next = nnn;
                    4'hB: pc_next = {4'd0, v_reg[0]} + nnn;
                    4'hC: v_next[fx] = rnd_reg & kk;
                    4'hD:
                    begin
                        // vf keeps its old value while drawing, so vx and vy stay put
                        mark_next  = 1'b1;
                        cnt_next   = '0;
                        hit_next   = 1'b0;
                        if (fn == 4'd0)
                            v_next[15] = 8'd0;
                        state_next = (fn == 4'd0) ? S_FINISH : S_DRADDR;
                    end
                    4'hE:
                    begin
                        if (kk == 8'h9E && keys_reg[vx[3:0]])
                            pc_next = pc_reg + 12'd4;
                        else if (kk == 8'hA1 && !keys_reg[vx[3:0]])
                            pc_next = pc_reg + 12'd4;
                    end
                    4'hF:
                    begin
                        unique case (kk)
                            8'h07: v_next[fx] = dly_reg;
                            8'h0A:
                            begin
                                if (key_hit)
                                    v_next[fx] = {4'd0, key_lo};
                                else
                                begin
                                    wait_next = 1'b1;
                                    pc_next   = pc_reg;
                                end
                            end
                            8'h15: dly_next = vx;
                            8'h18: snd_next = vx;
                            8'h1E:
                            begin
                                idx_next   = isum[11:0];
                                v_next[15] = {7'd0, isum[12]};
                            end
                            8'h29: idx_next = 12'({4'd0, vx} * 12'd5);
                            8'h33: state_next = S_BCD;
                            8'h55: state_next = S_STORE;
                            8'h65: state_next = S_LDADDR;
                            default: state_next = S_FINISH;
                        endcase
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_STKRD:
            begin
                stk_addr   = sp_reg[SAW-1:0];
                state_next = S_RET;
            end
            S_RET:
            begin
                pc_next = stk_rdata; state_next = S_FINISH;
            end
            S_DRADDR:
            begin
                mem_addr   = idx_reg + 12'(cnt_reg[3:0]);
                state_next = S_DRWAIT;
            end
            S_DRWAIT:
            begin
                spr_next   = mem_rdata;
                scr_addr   = ypos[RAW-1:0];
                state_next = S_DRROW;
            end
            S_DRROW:
            begin
                scr_addr   = ypos[RAW-1:0];
                state_next = S_DRWR;
            end
            S_DRWR:
            begin
                scr_addr  = ypos[RAW-1:0];
                scr_wdata = scr_rdata ^ spr_mask;
                if (ypos < 9'(SCREEN_ROWS))
                begin
                    scr_we = 1'b1;
                    if ((scr_rdata & spr_mask) != '0)
                        hit_next = 1'b1;
                end
                cnt_next = cnt_reg + MAW'(1);
                if (cnt_reg[3:0] == fn - 4'd1)
                begin
                    v_next[15] = {7'd0, hit_next};
                    state_next = S_FINISH;
                end
                else
                    state_next = S_DRADDR;
            end
            S_BCD:
            begin
                mem_we   = 1'b1;
                mem_addr = idx_reg + 12'(cnt_reg[1:0]);
                unique case (cnt_reg[1:0])
                    2'd0:    mem_wdata = {3'd0, bcd_h};
                    2'd1:    mem_wdata = {3'd0, bcd_t};
                    default: mem_wdata = {3'd0, bcd_o};
                endcase
                cnt_next = cnt_reg + MAW'(1);
                if (cnt_reg[1:0] == 2'd2)
                    state_next = S_FINISH;
            end
            S_STORE:
            begin
                mem_we    = 1'b1;
                mem_addr  = idx_reg + 12'(cnt_reg[3:0]);
                mem_wdata = v_reg[cnt_reg[3:0]];
                cnt_next  = cnt_reg + MAW'(1);
                if (cnt_reg[3:0] == fx)
                    state_next = S_FINISH;
            end
            S_LDADDR:
            begin
                mem_addr = idx_reg + 12'(cnt_reg[3:0]); state_next = S_LDWAIT;
            end
            S_LDWAIT:
            begin
                mem_addr = idx_reg + 12'(cnt_reg[3:0]); state_next = S_LDDATA;
            end
            S_LDDATA:
            begin
                v_next[cnt_reg[3:0]] = mem_rdata;
                cnt_next = cnt_reg + MAW'(1);
                state_next = (cnt_reg[3:0] == fx) ? S_FINISH : S_LDADDR;
            end
            S_FINISH:
            begin
                if (dly_reg != 8'd0)
                    dly_next = dly_reg - 8'd1;
                if (snd_reg != 8'd0)
                    snd_next = snd_reg - 8'd1;
                ob_next = 8'd0; orow_next = '0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    owait_next  = wait_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // result beat leaves
        if (ovalid_reg && !out_stall && state_reg != S_OUT)
            ovalid_next = 1'b0;
    end

    function automatic logic [7:0] font_val(input logic [MAW-1:0] a);
        if (a < MAW'(c8ic_pkg::FONT_SIZE))
            return c8ic_pkg::font_byte(a[6:0]);
        return 8'd0;
    endfunction

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLRMEM;
            pc_reg     <= c8ic_pkg::PC_START;
            idx_reg    <= '0;
            dly_reg    <= '0;
            snd_reg    <= '0;
            sp_reg     <= '0;
            mark_reg   <= 1'b1;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < 16; i++)
                v_reg[i] <= 8'd0;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            idx_reg    <= idx_next;
            dly_reg    <= dly_next;
            snd_reg    <= snd_next;
            sp_reg     <= sp_next;
            mark_reg   <= mark_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
            for (int i = 0; i < 16; i++)
                v_reg[i] <= v_next[i];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            keys_reg <= keys;
            rnd_reg  <= random_byte;
            rsel_reg <= row_select[RAW-1:0];
        end
        ins_reg   <= ins_next;
        spr_reg   <= spr_next;
        hit_reg   <= hit_next;
        wait_reg  <= wait_next;
        ob_reg    <= ob_next;
        orow_reg  <= orow_next;
        owait_reg <= owait_next;
    end

    // beat output, pc and flags sampled at hand over
    logic [11:0] opc_reg;
    logic        omark_reg, osnd_reg;
    logic [7:0]  obyte_reg;
    logic [SCREEN_COLS-1:0] orowq_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!ovalid_reg || !out_stall))
        begin
            opc_reg   <= pc_reg;
            omark_reg <= mark_reg;
            osnd_reg  <= (snd_reg != 8'd0);
            obyte_reg <= ob_reg;
            orowq_reg <= orow_reg;
        end
    end

    assign out_valid       = ovalid_reg;
    assign read_byte       = obyte_reg;
    assign screen_row      = orowq_reg;
    assign program_counter = opc_reg;
    assign draw_pending    = omark_reg;
    assign sound_on        = osnd_reg;
    assign waiting_key     = owait_reg;

endmodule

[tb/sv/tb_top.sv]
// testbench for the chip-8 instruction cycle block: programs and runs instructions, checks each result
`timescale 1ns / 1ps
module tb_top;

    localparam int LIMIT_CYCLES = 600000;
    localparam int BEAT_TARGET  = 1100;
    localparam int QUIET_FROM   = 1000;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] addr;
        logic [7:0]  data;
        logic [15:0] keys;
        logic [7:0]  rnd;
        logic [4:0]  rowsel;
    } beat_t;

    typedef struct packed {
        logic [7:0]  rd;
        logic [63:0] row;
        logic [11:0] pc;
        logic        draw;
        logic        snd;
        logic        wt;
    } outcome_t;

    typedef struct packed {
        beat_t    b;
        logic     typed;
        outcome_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] opcode = '0;
    logic [11:0] address = '0;
    logic [7:0] data_byte = '0;
    logic [15:0] keys = '0;
    logic [7:0] random_byte = '0;
    logic [4:0] row_select = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [7:0] read_byte;
    logic [63:0] screen_row;
    logic [11:0] program_counter;
    logic draw_pending;
    logic sound_on;
    logic waiting_key;

    chip8_instruction_cycle uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .address(address), .data_byte(data_byte),
        .keys(keys), .random_byte(random_byte), .row_select(row_select),
        .out_valid(out_valid), .out_stall(out_stall),
        .read_byte(read_byte), .screen_row(screen_row),
        .program_counter(program_counter), .draw_pending(draw_pending),
        .sound_on(sound_on), .waiting_key(waiting_key)
    );

    // predicted machine state
    c8ic_pkg::byte_t mem [0:4095];
    logic [63:0]     scr [0:31];
    c8ic_pkg::byte_t vreg [0:15];
    c8ic_pkg::addr_t stk [0:15];
    int              sp;
    c8ic_pkg::addr_t pc, idx;
    c8ic_pkg::byte_t dly, snd;
    logic            draw;

    outcome_t pending_results [$];
    int  errors = 0;
    int  beats_sent = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;
    int  stall_left = 0;

    always #5 clk = ~clk;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // advance the predicted machine by one beat
    task automatic cpu_apply(input beat_t b, output outcome_t r);
        logic [15:0]     ins;
        logic [3:0]      x, y;
        c8ic_pkg::byte_t kk, vx, vy, res, bits;
        c8ic_pkg::addr_t nnn;
        logic [8:0]      sum9;
        logic [12:0]     sum13;
        int              f, row, col;
        logic            wt;
        r = '0;
        wt = 1'b0;
        case (b.op)
            c8ic_pkg::OP_WRITE: mem[b.addr] = b.data;
            c8ic_pkg::OP_ROW:   r.row = scr[b.rowsel];
            c8ic_pkg::OP_READ:  r.rd = mem[b.addr];
            c8ic_pkg::OP_EXEC:
            begin
                ins = {mem[pc], mem[c8ic_pkg::addr_t'(pc + 12'd1)]};
                x = ins[11:8];
                y = ins[7:4];
                kk = ins[7:0];
                nnn = ins[11:0];
                vx = vreg[x];
                vy = vreg[y];
                pc = pc + 12'd2;
                case (ins[15:12])
                    4'h0:
                    begin
                        if (ins == 16'h00E0)
                            for (int i = 0; i < 32; i++) scr[i] = '0;
                        else if (ins == 16'h00EE && sp > 0)
                        begin
                            sp--;
                            pc = stk[sp];
                        end
                    end
                    4'h1: pc = nnn;
                    4'h2:
                    begin
                        if (sp < c8ic_pkg::STACK_DEPTH)
                        begin
                            stk[sp] = pc;
                            sp++;
                            pc = nnn;
                        end
                    end
                    4'h3: if (vx == kk) pc = pc + 12'd2;
                    4'h4: if (vx != kk) pc = pc + 12'd2;
                    4'h5: if (vx == vy) pc = pc + 12'd2;
                    4'h6: vreg[x] = kk;
                    4'h7: vreg[x] = vx + kk;
                    4'h8:
                    begin
                        f = 2;
                        case (ins[3:0])
                            4'h0: res = vy;
                            4'h1: res = vx | vy;
                            4'h2: res = vx & vy;
                            4'h3: res = vx ^ vy;
                            4'h4: begin sum9 = vx + vy; res = sum9[7:0]; f = sum9[8]; end
                            4'h5: begin res = vx - vy; f = (vx >= vy); end
                            4'h6: begin res = vx >> 1; f = vx[0]; end
                            4'h7: begin res = vy - vx; f = (vy >= vx); end
                            4'hE: begin res = vx << 1; f = vx[7]; end
                            default: res = vx;
                        endcase
                        vreg[x] = res;
                        if (f != 2) vreg[15] = c8ic_pkg::byte_t'(f);
                    end
                    4'h9: if (vx != vy) pc = pc + 12'd2;
                    4'hA: idx = nnn;
                    4'hB: pc = {4'b0, vreg[0]} + nnn;
                    4'hC: vreg[x] = b.rnd & kk;
                    4'hD:
                    begin
                        // xor sprite in, clipped at the right and bottom edges
                        vreg[15] = 8'd0;
                        for (int i = 0; i < ins[3:0]; i++)
                        begin
                            bits = mem[c8ic_pkg::addr_t'(idx + i)];
                            row = vy + i;
                            if (row < 32)
                                for (int j = 0; j < 8; j++)
                                begin
                                    col = vx + j;
                                    if (bits[7-j] && col < 64)
                                    begin
                                        if (scr[row][63-col]) vreg[15] = 8'd1;
                                        scr[row][63-col] = ~scr[row][63-col];
                                    end
                                end
                        end
                        draw = 1'b1;
                    end
                    4'hE:
                    begin
                        if (kk == 8'h9E && b.keys[vx[3:0]]) pc = pc + 12'd2;
                        else if (kk == 8'hA1 && !b.keys[vx[3:0]]) pc = pc + 12'd2;
                    end
                    4'hF:
                    begin
                        case (kk)
                            8'h07: vreg[x] = dly;
                            8'h0A:
                            begin
                                wt = 1'b1;
                                for (int i = 0; i < 16; i++)
                                    if (wt && b.keys[i])
                                    begin
                                        vreg[x] = c8ic_pkg::byte_t'(i);
                                        wt = 1'b0;
                                    end
                                if (wt) pc = pc - 12'd2;
                            end
                            8'h15: dly = vx;
                            8'h18: snd = vx;
                            8'h1E:
                            begin
                                sum13 = idx + vx;
                                idx = sum13[11:0];
                                vreg[15] = {7'd0, sum13[12]};
                            end
                            8'h29: idx = c8ic_pkg::addr_t'(vx * 5);
                            8'h33:
                            begin
                                mem[idx] = c8ic_pkg::byte_t'(vx / 100);
                                mem[c8ic_pkg::addr_t'(idx + 12'd1)] =
                                    c8ic_pkg::byte_t'((vx / 10) % 10);
                                mem[c8ic_pkg::addr_t'(idx + 12'd2)] = c8ic_pkg::byte_t'(vx % 10);
                            end
                            8'h55:
                                for (int i = 0; i <= x; i++)
                                    mem[c8ic_pkg::addr_t'(idx + i)] = vreg[i];
                            8'h65:
                                for (int i = 0; i <= x; i++)
                                    vreg[i] = mem[c8ic_pkg::addr_t'(idx + i)];
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
                if (dly != 0) dly--;
                if (snd != 0) snd--;
            end
        endcase
        r.pc = pc;
        r.draw = draw;
        r.snd = (snd != 0);
        r.wt = wt;
    endtask

    function automatic beat_t any_beat(input logic [1:0] op);
        beat_t b;
        b = beat_t'({$urandom, $urandom});
        b.op = op;
        return b;
    endfunction

    // random instruction, steered towards the defined patterns
    function automatic logic [15:0] pick_instr();
        logic [15:0] w;
        logic [7:0]  fk [0:9];
        fk = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65, 8'h00};
        w = 16'($urandom);
        case (w[15:12])
            4'h0:
                case ($urandom_range(0, 2))
                    0: w = 16'h00E0;
                    1: w = 16'h00EE;
                    default: ;
                endcase
            4'h3, 4'h4: if ($urandom_range(0, 1)) w[7:0] = vreg[w[11:8]];
            4'hD: if ($urandom_range(0, 3) == 0) w[11:4] = 8'h00;
            4'hE:
                case ($urandom_range(0, 2))
                    0: w[7:0] = 8'h9E;
                    1: w[7:0] = 8'hA1;
                    default: ;
                endcase
            4'hF:
            begin
                w[7:0] = fk[$urandom_range(0, 9)];
                if (w[7:0] == 8'h00) w[7:0] = 8'($urandom);
            end
            default: ;
        endcase
        return w;
    endfunction

    // predict, then hold the beat until the block takes it
    task automatic send_beat(input beat_t b, input logic typed, input outcome_t want);
        outcome_t r;
        cpu_apply(b, r);
        pending_results.push_back(typed ? want : r);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= b.op;
        address     <= b.addr;
        data_byte   <= b.data;
        keys        <= b.keys;
        random_byte <= b.rnd;
        row_select  <= b.rowsel;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
    endtask

    // load one instruction at the current pc and run it
    task automatic run_instr(input logic [15:0] w, input logic [15:0] k);
        beat_t b;
        b = any_beat(c8ic_pkg::OP_WRITE);
        b.addr = pc;
        b.data = w[15:8];
        send_beat(b, 1'b0, '0);
        b = any_beat(c8ic_pkg::OP_WRITE);
        b.addr = pc + 12'd1;
        b.data = w[7:0];
        send_beat(b, 1'b0, '0);
        b = any_beat(c8ic_pkg::OP_EXEC);
        b.keys = k;
        send_beat(b, 1'b0, '0);
    endtask

    // result side: random stall bursts, compare every beat taken
    always @(posedge clk)
    begin
        outcome_t e;
        cycles <= cycles + 1;
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report("unexpected beat", 64'd0, 64'd0);
            else
            begin
                e = pending_results.pop_front();
                if (read_byte !== e.rd) report("read_byte", read_byte, e.rd);
                if (screen_row !== e.row) report("screen_row", screen_row, e.row);
                if (program_counter !== e.pc) report("program_counter", program_counter, e.pc);
                if (draw_pending !== e.draw) report("draw_pending", draw_pending, e.draw);
                if (sound_on !== e.snd) report("sound_on", sound_on, e.snd);
                if (waiting_key !== e.wt) report("waiting_key", waiting_key, e.wt);
            end
        end
    end

    // overall time limit
    always @(posedge clk)
    begin
        if (cycles == LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        dir_row_t dir_tab [$];
        // the first typed rows come straight after reset: pc 200, draw mark set, sound off
        dir_tab = '{
            '{'{c8ic_pkg::OP_READ,  12'h000, 8'h00, 16'h0000, 8'h00, 5'd0},  1'b1,
              '{8'hF0, 64'd0, 12'h200, 1'b1, 1'b0, 1'b0}},
            '{'{c8ic_pkg::OP_READ,  12'h04F, 8'hFF, 16'hFFFF, 8'hFF, 5'd31}, 1'b1,
              '{8'h80, 64'd0, 12'h200, 1'b1, 1'b0, 1'b0}},
            '{'{c8ic_pkg::OP_READ,  12'h050, 8'h00, 16'h0000, 8'h00, 5'd0},  1'b1,
              '{8'h00, 64'd0, 12'h200, 1'b1, 1'b0, 1'b0}},
            '{'{c8ic_pkg::OP_READ,  12'hFFF, 8'h00, 16'h0000, 8'h00, 5'd0},  1'b1,
              '{8'h00, 64'd0, 12'h200, 1'b1, 1'b0, 1'b0}},
            '{'{c8ic_pkg::OP_ROW,   12'hFFF, 8'hFF, 16'hFFFF, 8'hFF, 5'd0},  1'b1,
              '{8'h00, 64'd0, 12'h200, 1'b1, 1'b0, 1'b0}},
            '{'{c8ic_pkg::OP_ROW,   12'h000, 8'h00, 16'h0000, 8'h00, 5'd31}, 1'b1,
              '{8'h00, 64'd0, 12'h200, 1'b1, 1'b0, 1'b0}},
            '{'{c8ic_pkg::OP_WRITE, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF, 5'd31}, 1'b1,
              '{8'h00, 64'd0, 12'h200, 1'b1, 1'b0, 1'b0}},
            '{'{c8ic_pkg::OP_READ,  12'hFFF, 8'h00, 16'h0000, 8'h00, 5'd0},  1'b1,
              '{8'hFF, 64'd0, 12'h200, 1'b1, 1'b0, 1'b0}},
            '{'{c8ic_pkg::OP_WRITE, 12'h200, 8'h60, 16'h0000, 8'h00, 5'd0},  1'b0, '0},
            '{'{c8ic_pkg::OP_WRITE, 12'h201, 8'hFF, 16'h0000, 8'h00, 5'd0},  1'b0, '0},
            '{'{c8ic_pkg::OP_EXEC,  12'h000, 8'h00, 16'h0000, 8'h00, 5'd0},  1'b1,
              '{8'h00, 64'd0, 12'h202, 1'b1, 1'b0, 1'b0}},
            '{'{c8ic_pkg::OP_WRITE, 12'h202, 8'hF1, 16'h0000, 8'h00, 5'd0},  1'b0, '0},
            '{'{c8ic_pkg::OP_WRITE, 12'h203, 8'h0A, 16'h0000, 8'h00, 5'd0},  1'b0, '0},
            // wait for key with nothing pressed holds pc
            '{'{c8ic_pkg::OP_EXEC,  12'h000, 8'h00, 16'h0000, 8'h00, 5'd0},  1'b1,
              '{8'h00, 64'd0, 12'h202, 1'b1, 1'b0, 1'b1}},
            '{'{c8ic_pkg::OP_EXEC,  12'h000, 8'h00, 16'h8000, 8'h00, 5'd0},  1'b1,
              '{8'h00, 64'd0, 12'h204, 1'b1, 1'b0, 1'b0}},
            '{'{c8ic_pkg::OP_WRITE, 12'h204, 8'hC2, 16'h0000, 8'h00, 5'd0},  1'b0, '0},
            '{'{c8ic_pkg::OP_WRITE, 12'h205, 8'hFF, 16'h0000, 8'h00, 5'd0},  1'b0, '0},
            '{'{c8ic_pkg::OP_EXEC,  12'hFFF, 8'hFF, 16'hFFFF, 8'hFF, 5'd31}, 1'b0, '0},
            // sprite past the right edge, clipped
            '{'{c8ic_pkg::OP_WRITE, 12'h206, 8'hD0, 16'h0000, 8'h00, 5'd0},  1'b0, '0},
            '{'{c8ic_pkg::OP_WRITE, 12'h207, 8'h1F, 16'h0000, 8'h00, 5'd0},  1'b0, '0},
            '{'{c8ic_pkg::OP_EXEC,  12'h000, 8'h00, 16'h0000, 8'h00, 5'd0},  1'b0, '0},
            '{'{c8ic_pkg::OP_ROW,   12'h000, 8'h00, 16'h0000, 8'h00, 5'd31}, 1'b0, '0},
            '{'{c8ic_pkg::OP_ROW,   12'h000, 8'h00, 16'h0000, 8'h00, 5'd2},  1'b0, '0}
        };

        // predicted state after reset
        for (int i = 0; i < 4096; i++)
            mem[i] = (i < c8ic_pkg::FONT_SIZE) ? c8ic_pkg::font_byte(i[6:0]) : 8'h00;
        for (int i = 0; i < 32; i++) scr[i] = '0;
        for (int i = 0; i < 16; i++) begin vreg[i] = 8'h00; stk[i] = '0; end
        sp = 0;
        pc = c8ic_pkg::PC_START;
        idx = '0;
        dly = 8'h00;
        snd = 8'h00;
        draw = 1'b1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_beat(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);

        // nested calls past the stack depth, then returns past empty
        for (int i = 0; i < c8ic_pkg::STACK_DEPTH + 2; i++)
            run_instr({4'h2, 12'(($urandom_range(0, 255) << 4) + 12'h300)}, 16'($urandom));
        for (int i = 0; i < c8ic_pkg::STACK_DEPTH + 2; i++)
            run_instr(16'h00EE, 16'($urandom));

        // random programs with a little noise
        while (beats_sent < BEAT_TARGET)
        begin
            if (beats_sent >= QUIET_FROM) quiet = 1'b1;
            if (beats_sent > 550 && beats_sent < 560)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0) @(posedge clk);
            end
            case ($urandom_range(0, 19))
                0:  send_beat(any_beat(c8ic_pkg::OP_ROW), 1'b0, '0);
                1:  send_beat(any_beat(c8ic_pkg::OP_READ), 1'b0, '0);
                2:  send_beat(any_beat(c8ic_pkg::OP_WRITE), 1'b0, '0);
                3:  send_beat(any_beat(c8ic_pkg::OP_EXEC), 1'b0, '0);
                default:
                    run_instr(pick_instr(),
                              ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom));
            endcase
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
